[hw/rtl/satd_pkg.sv]
// shared types, constants and the 4-point hadamard butterfly for the satd block
// no dependencies; used by every module under hw/rtl
`default_nettype none

package satd_pkg;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int CFG_W          = 3;
    localparam int MAX_SIDE       = 4;
    localparam int TOTAL_W        = 5;   // holds MAX_SIDE * MAX_SIDE
    localparam int PIX_W          = 8;
    localparam int HCOEF_W        = 11;  // row coefficient, -1020..1020
    localparam int WCOEF_W        = 13;  // column coefficient, -4080..4080
    localparam int ABS_W          = 12;
    localparam int COLSUM_W       = 14;
    localparam int SUBSUM_W       = 16;
    localparam int ACC_W          = 20;
    localparam int SATD_W         = 19;
    localparam int OUT_TDATA_W    = 24;
    localparam int IN_TDATA_W     = 64;
    localparam int COUNT_W        = 4;

    // row position inside a 4x4 sub-block
    localparam logic [1:0] LAST_ROW = 2'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef logic [3:0][WCOEF_W-1:0] wide_vec_t;
    typedef logic [3:0][HCOEF_W-1:0] row_vec_t;

    typedef struct packed {
        logic [1:0] row;
        row_vec_t   coef;
    } row_item_t;

    // butterfly, outputs in satd order
    function automatic wide_vec_t hadamard4(input wide_vec_t a);
        logic [WCOEF_W-1:0] s01;
        logic [WCOEF_W-1:0] s23;
        logic [WCOEF_W-1:0] d01;
        logic [WCOEF_W-1:0] d23;
        wide_vec_t          o;
        s01  = a[0] + a[1];
        s23  = a[2] + a[3];
        d01  = a[0] - a[1];
        d23  = a[2] - a[3];
        o[0] = s01 + s23;
        o[1] = s01 - s23;
        o[2] = d01 - d23;
        o[3] = d01 + d23;
        return o;
    endfunction

    // zero reads as one, anything above the maximum saturates
    function automatic logic [CFG_W-1:0] side_clamp(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(MAX_SIDE))
            r = CFG_W'(MAX_SIDE);
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/satd_front.sv]
// front end: differences, horizontal butterfly and row tagging
// depends on satd_pkg
`default_nettype none

module satd_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [satd_pkg::IN_TDATA_W-1:0]   pixels,
    output satd_pkg::row_item_t                    item
);

    logic [1:0]          row_reg;
    logic [1:0]          row_next;
    satd_pkg::wide_vec_t diff;
    satd_pkg::wide_vec_t hrow;

    // row counter inside the current sub-block
    always_comb
    begin
        row_next = row_reg;
        if (accept)
            row_next = row_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= 2'd0;
        else
            row_reg <= row_next;
    end

    // cur - ref per column, then the row butterfly
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = {5'b0, pixels[i*satd_pkg::PIX_W +: satd_pkg::PIX_W]}
                    - {5'b0, pixels[(i+4)*satd_pkg::PIX_W +: satd_pkg::PIX_W]};
        end
        hrow = satd_pkg::hadamard4(diff);
        item.row = row_reg;
        for (int i = 0; i < 4; i++)
        begin
            item.coef[i] = hrow[i][satd_pkg::HCOEF_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/satd_queue.sv]
// short fifo of transformed rows between front and back
// depends on satd_pkg
`default_nettype none

module satd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire satd_pkg::row_item_t  push_item,
    input  wire logic                 pop,
    output satd_pkg::row_item_t       head,
    output logic                      full,
    output logic                      empty
);

    satd_pkg::row_item_t                entry_reg [satd_pkg::QUEUE_DEPTH];
    logic [satd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [satd_pkg::QUEUE_AW-1:0]      wr_ptr_next;
    logic [satd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [satd_pkg::QUEUE_AW-1:0]      rd_ptr_next;
    logic [satd_pkg::QUEUE_AW:0]        count_reg;
    logic [satd_pkg::QUEUE_AW:0]        count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == (satd_pkg::QUEUE_AW+1)'(satd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[hw/rtl/satd_back.sv]
// back end: row buffer, column butterflies, absolute sums, accumulation and
// the output register; depends on satd_pkg
`default_nettype none

module satd_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire satd_pkg::row_item_t                 head,
    input  wire logic                                empty,
    output logic                                     pop,
    input  wire logic [satd_pkg::TOTAL_W-1:0]        total_blocks,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [satd_pkg::SATD_W-1:0]              satd_value
);

    logic                                       advance;
    logic [satd_pkg::HCOEF_W-1:0]               store_reg [3][4];
    logic                                       s1_valid_reg;
    satd_pkg::wide_vec_t                        s1_coef_reg [4];
    satd_pkg::wide_vec_t                        s1_coef_next [4];
    logic                                       s2_valid_reg;
    logic [satd_pkg::COLSUM_W-1:0]              s2_sum_reg [4];
    logic [satd_pkg::COLSUM_W-1:0]              s2_sum_next [4];
    logic [satd_pkg::ACC_W-1:0]                 acc_reg;
    logic [satd_pkg::ACC_W-1:0]                 acc_next;
    logic [satd_pkg::COUNT_W-1:0]               count_reg;
    logic [satd_pkg::COUNT_W-1:0]               count_next;
    logic [satd_pkg::SUBSUM_W-1:0]              sub_sum;
    logic [satd_pkg::ACC_W-1:0]                 acc_sum;
    logic [satd_pkg::TOTAL_W-1:0]               count_inc;
    logic                                       finish;
    logic                                       out_valid_reg;
    logic                                       out_valid_next;
    logic [satd_pkg::SATD_W-1:0]                out_data_reg;

    // whole back end moves together unless the result register is blocked
    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && !empty;
    assign out_valid = out_valid_reg;
    assign satd_value = out_data_reg;

    // rows 0..2 of a sub-block are buffered
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (pop && head.row == 2'(r))
                    store_reg[r][i] <= head.coef[i];
            end
        end
    end

    // column butterflies on the last row
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            satd_pkg::wide_vec_t col;
            col[0] = {{2{store_reg[0][i][10]}}, store_reg[0][i]};
            col[1] = {{2{store_reg[1][i][10]}}, store_reg[1][i]};
            col[2] = {{2{store_reg[2][i][10]}}, store_reg[2][i]};
            col[3] = {{2{head.coef[i][10]}}, head.coef[i]};
            s1_coef_next[i] = satd_pkg::hadamard4(col);
        end
    end

    // absolute values summed per column
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [satd_pkg::COLSUM_W-1:0] acc_col;
            acc_col = '0;
            for (int k = 0; k < 4; k++)
            begin
                logic [satd_pkg::WCOEF_W-1:0] v;
                logic [satd_pkg::WCOEF_W-1:0] mag;
                v   = s1_coef_reg[i][k];
                mag = v[satd_pkg::WCOEF_W-1] ? (~v + 1'b1) : v;
                acc_col = acc_col + {2'b0, mag[satd_pkg::ABS_W-1:0]};
            end
            s2_sum_next[i] = acc_col;
        end
    end

    // sub-block total, accumulation and end-of-block check
    always_comb
    begin
        sub_sum = {2'b0, s2_sum_reg[0]} + {2'b0, s2_sum_reg[1]}
                + {2'b0, s2_sum_reg[2]} + {2'b0, s2_sum_reg[3]};
        acc_sum   = acc_reg + {4'b0, sub_sum};
        count_inc = {1'b0, count_reg} + 1'b1;
        finish    = s2_valid_reg && (count_inc >= total_blocks);
        acc_next   = acc_reg;
        count_next = count_reg;
        if (s2_valid_reg)
        begin
            if (finish)
            begin
                acc_next   = '0;
                count_next = '0;
            end
            else
            begin
                acc_next   = acc_sum;
                count_next = count_inc[satd_pkg::COUNT_W-1:0];
            end
        end
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
            out_valid_next = finish;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                s1_valid_reg <= pop && (head.row == satd_pkg::LAST_ROW);
                s2_valid_reg <= s1_valid_reg;
                acc_reg      <= acc_next;
                count_reg    <= count_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_coef_reg[i] <= s1_coef_next[i];
                s2_sum_reg[i]  <= s2_sum_next[i];
            end
            if (finish)
                out_data_reg <= acc_sum[satd_pkg::ACC_W-1:1];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/block_satd_hadamard4x4.sv]
// top level of the 4x4 hadamard satd block: configuration registers and the
// front / queue / back chain; depends on satd_pkg, satd_front, satd_queue, satd_back
`default_nettype none

// Takes one 4-pixel row of a 4x4 sub-block per transaction on the slave side
// (four rows per sub-block, sub-blocks in any order) and, once
// width_in_fours * height_in_fours sub-blocks have been summed, delivers one
// transaction on the master side holding the block satd halved. A row is
// accepted every clock cycle while the four-entry row queue has room; the
// back end runs at one row per cycle too and stalls only while its result
// register is held by the master side. The result is registered once the fourth row
// of the last sub-block has passed the row queue, the column butterflies, the absolute
// column sums and the accumulation into the result register.
// Register values of zero read as one, values above four as four; write them
// only between blocks.
module block_satd_hadamard4x4 (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // slave side: cur_pixel_0..3, ref_pixel_0..3, 8 bits each from bit 0 up
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [satd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // master side: satd_value in bits 18:0, rest zero
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [satd_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [satd_pkg::CFG_W-1:0]          cfg_data
);

    logic [satd_pkg::CFG_W-1:0]     width_reg;
    logic [satd_pkg::CFG_W-1:0]     width_next;
    logic [satd_pkg::CFG_W-1:0]     height_reg;
    logic [satd_pkg::CFG_W-1:0]     height_next;
    logic [satd_pkg::TOTAL_W-1:0]   total_blocks;
    logic                           accept;
    logic                           q_full;
    logic                           q_empty;
    logic                           q_pop;
    satd_pkg::row_item_t            front_item;
    satd_pkg::row_item_t            q_head;
    logic [satd_pkg::SATD_W-1:0]    satd_value;

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                satd_pkg::CFG_WIDTH:  width_next  = cfg_data;
                satd_pkg::CFG_HEIGHT: height_next = cfg_data;
                default:              width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= satd_pkg::CFG_W'(satd_pkg::MAX_SIDE);
            height_reg <= satd_pkg::CFG_W'(satd_pkg::MAX_SIDE);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // sub-blocks per block
    assign total_blocks = {2'b0, satd_pkg::side_clamp(width_reg)}
                        * {2'b0, satd_pkg::side_clamp(height_reg)};

    // input handshake
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    satd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixels (s_tdata),
        .item   (front_item)
    );

    satd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    satd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .total_blocks (total_blocks),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .satd_value   (satd_value)
    );

    assign m_tdata = {{(satd_pkg::OUT_TDATA_W - satd_pkg::SATD_W){1'b0}}, satd_value};

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for block_satd_hadamard4x4: streams 4x4 sub-block pixel rows under random
// idling and checks every block satd against a cycle-free predictor; needs satd_pkg and rtl
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int ROWS_PER_PHASE  = 360;
    localparam int SIDE_MAX        = 4;

    // one pixel row; cur_px[0] lands in tdata bits 7:0, ref_px[3] in bits 63:56
    typedef struct packed {
        logic [3:0][7:0] ref_px;
        logic [3:0][7:0] cur_px;
    } pixel_row_t;

    typedef enum int {
        ROW_RANDOM,
        ROW_EXTREME,
        ROW_EQUAL,
        ROW_MAX_POS,
        ROW_MAX_NEG,
        ROW_CHECKER
    } row_kind_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [satd_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [satd_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                cfg_we = 1'b0;
    logic                                cfg_index = 1'b0;
    logic [satd_pkg::CFG_W-1:0]          cfg_data = '0;

    // stimulus and expectations
    pixel_row_t                          pending_rows[$];
    logic [satd_pkg::SATD_W-1:0]         expected_satd[$];
    logic [satd_pkg::SATD_W-1:0]         oldest_satd;
    int unsigned                         send_idle_pct = 0;
    int unsigned                         recv_stall_pct = 0;
    int                                  mismatch_count = 0;
    int                                  quiet_cycles = 0;

    // predictor copies of the registers and the block state
    logic [satd_pkg::CFG_W-1:0]          width_reg = 3'd4;
    logic [satd_pkg::CFG_W-1:0]          height_reg = 3'd4;
    logic signed [10:0]                  row_store [0:11];
    logic [1:0]                          row_pos = 2'd0;
    logic [4:0]                          done_subblocks = 5'd0;
    logic [19:0]                         satd_acc = 20'd0;

    block_satd_hadamard4x4 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // 4-point hadamard, outputs in satd order
    task automatic butterfly4(input int a0, input int a1, input int a2, input int a3,
                              output int o0, output int o1, output int o2, output int o3);
        int s01;
        int s23;
        int d01;
        int d23;
        s01 = a0 + a1;
        s23 = a2 + a3;
        d01 = a0 - a1;
        d23 = a2 - a3;
        o0  = s01 + s23;
        o1  = s01 - s23;
        o2  = d01 - d23;
        o3  = d01 + d23;
    endtask

    // zero counts as one, above the maximum saturates
    function automatic int clamp_side(input logic [satd_pkg::CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > SIDE_MAX)
            return SIDE_MAX;
        return int'(v);
    endfunction

    // row transform, buffering, column transform and block total for one row
    task automatic accept_row(input pixel_row_t r);
        int d[4];
        int h[4];
        int c[4];
        int block_sum;
        int subblocks_needed;
        int i;
        int k;
        block_sum = 0;
        for (i = 0; i < 4; i++)
            d[i] = int'(r.cur_px[i]) - int'(r.ref_px[i]);
        butterfly4(d[0], d[1], d[2], d[3], h[0], h[1], h[2], h[3]);
        if (row_pos != satd_pkg::LAST_ROW)
        begin
            for (i = 0; i < 4; i++)
                row_store[int'(row_pos) * 4 + i] = h[i][10:0];
            row_pos = row_pos + 2'd1;
        end
        else
        begin
            for (i = 0; i < 4; i++)
            begin
                butterfly4(row_store[i], row_store[4 + i], row_store[8 + i], h[i],
                           c[0], c[1], c[2], c[3]);
                for (k = 0; k < 4; k++)
                    block_sum += (c[k] < 0) ? -c[k] : c[k];
            end
            satd_acc       = satd_acc + 20'(block_sum);
            row_pos        = 2'd0;
            done_subblocks = done_subblocks + 5'd1;
            subblocks_needed = clamp_side(width_reg) * clamp_side(height_reg);
            if (int'(done_subblocks) >= subblocks_needed)
            begin
                expected_satd.push_back(satd_acc[19:1]);
                satd_acc       = 20'd0;
                done_subblocks = 5'd0;
            end
        end
    endtask

    function automatic pixel_row_t make_row(input row_kind_t kind, input int row_idx);
        pixel_row_t r;
        int col;
        for (col = 0; col < 4; col++)
        begin
            case (kind)
                ROW_EXTREME:
                begin
                    r.cur_px[col] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    r.ref_px[col] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                end
                ROW_EQUAL:
                begin
                    r.cur_px[col] = 8'($urandom_range(0, 255));
                    r.ref_px[col] = r.cur_px[col];
                end
                ROW_MAX_POS:
                begin
                    r.cur_px[col] = 8'hff;
                    r.ref_px[col] = 8'h00;
                end
                ROW_MAX_NEG:
                begin
                    r.cur_px[col] = 8'h00;
                    r.ref_px[col] = 8'hff;
                end
                ROW_CHECKER:
                begin
                    r.cur_px[col] = ((col + row_idx) % 2 != 0) ? 8'hff : 8'h00;
                    r.ref_px[col] = ~r.cur_px[col];
                end
                default:
                begin
                    r.cur_px[col] = 8'($urandom_range(0, 255));
                    r.ref_px[col] = 8'($urandom_range(0, 255));
                end
            endcase
        end
        return r;
    endfunction

    task automatic queue_rows(input row_kind_t kind, input int count);
        int i;
        @(negedge clk);
        for (i = 0; i < count; i++)
            pending_rows.push_back(make_row(kind, i));
    endtask

    // mostly random content, with a share of extreme, flat and saturated rows
    task automatic queue_mixed_rows(input int count);
        int i;
        int pick;
        row_kind_t kind;
        @(negedge clk);
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       kind = ROW_EXTREME;
                1:       kind = ROW_EQUAL;
                2:       kind = ROW_MAX_POS;
                3:       kind = ROW_MAX_NEG;
                default: kind = ROW_RANDOM;
            endcase
            pending_rows.push_back(make_row(kind, i));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [satd_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // all rows taken, all results seen, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        while (pending_rows.size() != 0 || s_tvalid || expected_satd.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // driver: next row whenever the slot is free and the sender is not idling
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_rows.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: register writes, result checks, then prediction of accepted rows
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg      = 3'd4;
            height_reg     = 3'd4;
            row_pos        = 2'd0;
            done_subblocks = 5'd0;
            satd_acc       = 20'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == satd_pkg::CFG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_satd.size() == 0)
                begin
                    $error("satd_value: no transaction expected, actual %0d",
                           m_tdata[satd_pkg::SATD_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    oldest_satd = expected_satd.pop_front();
                    if (m_tdata[satd_pkg::SATD_W-1:0] !== oldest_satd)
                    begin
                        $error("satd_value: expected %0d, actual %0d",
                               oldest_satd, m_tdata[satd_pkg::SATD_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                accept_row(pixel_row_t'(s_tdata));
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int phase_rows;
        int setting;
        int rows;
        logic [satd_pkg::CFG_W-1:0] w;
        logic [satd_pkg::CFG_W-1:0] h;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // single sub-block blocks: saturated, flat and high-frequency content
        write_reg(satd_pkg::CFG_WIDTH, 3'd1);
        write_reg(satd_pkg::CFG_HEIGHT, 3'd1);
        queue_rows(ROW_MAX_POS, 4);
        queue_rows(ROW_MAX_NEG, 4);
        queue_rows(ROW_EQUAL, 4);
        queue_rows(ROW_CHECKER, 4);
        wait_idle();

        // shrink the block size mid-block: the next finished sub-block closes it
        write_reg(satd_pkg::CFG_HEIGHT, 3'd2);
        queue_rows(ROW_RANDOM, 4);
        wait_idle();
        write_reg(satd_pkg::CFG_HEIGHT, 3'd1);
        queue_rows(ROW_RANDOM, 4);
        wait_idle();

        // random blocks under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            phase_rows = 0;
            setting    = 0;
            while (phase_rows < ROWS_PER_PHASE)
            begin
                // first settings go through zero, maximum code, one and four
                if (phase == 0 && setting < 4)
                begin
                    case (setting)
                        0:       begin w = 3'd0; h = 3'd0; end
                        1:       begin w = 3'd7; h = 3'd7; end
                        2:       begin w = 3'd1; h = 3'd4; end
                        default: begin w = 3'd4; h = 3'd1; end
                    endcase
                end
                else
                begin
                    w = 3'($urandom_range(0, 7));
                    h = 3'($urandom_range(0, 7));
                end
                write_reg(satd_pkg::CFG_WIDTH, w);
                write_reg(satd_pkg::CFG_HEIGHT, h);
                rows = $urandom_range(1, 3) * 4 * clamp_side(w) * clamp_side(h);
                queue_mixed_rows(rows);
                wait_idle();
                phase_rows += rows;
                setting++;
            end
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
